### rtl/svc_pkg.sv
package svc_pkg;

  localparam int unsigned VALUE_W = 32;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned MAX_BYTES = 5;

  localparam logic [1:0] RK_BYTE  = 2'd0;
  localparam logic [1:0] RK_VALUE = 2'd1;
  localparam logic [1:0] RK_TRUNC = 2'd2;

  localparam logic KIND_DECODE = 1'b0;
  localparam logic KIND_ENCODE = 1'b1;

  localparam logic [31:0] MASK_LEN1 = 32'hFFFF_FFC0;
  localparam logic [31:0] MASK_LEN2 = 32'hFFFF_E000;
  localparam logic [31:0] MASK_LEN3 = 32'hFFF0_0000;
  localparam logic [31:0] MASK_LEN4 = 32'hF800_0000;
  localparam logic [31:0] MASK_LEN5 = 32'h8000_0000;

  localparam logic [31:0] POS_LIM1 = 32'h0000_0040;
  localparam logic [31:0] POS_LIM2 = 32'h0000_2000;
  localparam logic [31:0] POS_LIM3 = 32'h0010_0000;
  localparam logic [31:0] POS_LIM4 = 32'h0800_0000;

  typedef logic [MAX_BYTES-1:0][BYTE_W-1:0] enc_bytes_t;

  typedef struct packed {
    logic              valid;
    logic [1:0]        kind;
    logic [VALUE_W-1:0] value;
  } dec_res_t;

endpackage

### rtl/signed_varint_codec_core.sv
// Decode: one byte per cycle while in_stall is low; its result (if any) is registered the
// cycle after acceptance. Encode: a value of n bytes (1 to 5) yields one byte per cycle
// while out_stall is low, the first registered the cycle after acceptance; in_stall holds
// until all n are sent. The output register sets throughput, one result per unstalled cycle.
// Synchronous reset clears the decode state, the pending byte queue and out_valid.
module signed_varint_codec_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               kind,
  input  logic [7:0]         in_byte,
  input  logic signed [31:0] in_value,
  input  logic               buffer_end,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         result_kind,
  output logic [7:0]         out_byte,
  output logic signed [31:0] out_value,
  output logic               last
);

  logic                 accept_in;
  logic                 out_free;
  logic [2:0]           enc_count;
  svc_pkg::enc_bytes_t  enc_bytes;
  svc_pkg::dec_res_t    dec;

  logic [3:0][7:0]      pend;
  logic [2:0]           pend_cnt;

  assign out_free  = !out_valid || !out_stall;
  assign in_stall  = (pend_cnt != 3'd0) || !out_free;
  assign accept_in = in_valid && !in_stall;

  svc_enc u_enc (
    .value     (in_value),
    .count     (enc_count),
    .enc_bytes (enc_bytes)
  );

  svc_dec u_dec (
    .clk        (clk),
    .rst        (rst),
    .take       (accept_in && (kind == svc_pkg::KIND_DECODE)),
    .in_byte    (in_byte),
    .buffer_end (buffer_end),
    .dec        (dec)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      pend_cnt  <= '0;
    end else if (accept_in) begin
      if (kind == svc_pkg::KIND_ENCODE) begin
        out_valid   <= 1'b1;
        result_kind <= svc_pkg::RK_BYTE;
        out_byte    <= enc_bytes[0];
        out_value   <= '0;
        last        <= (enc_count == 3'd1);
        pend        <= enc_bytes[4:1];
        pend_cnt    <= enc_count - 3'd1;
      end else begin
        out_valid   <= dec.valid;
        result_kind <= dec.kind;
        out_byte    <= '0;
        out_value   <= dec.value;
        last        <= 1'b1;
      end
    end else if ((pend_cnt != 3'd0) && out_free) begin
      out_valid   <= 1'b1;
      result_kind <= svc_pkg::RK_BYTE;
      out_byte    <= pend[0];
      out_value   <= '0;
      last        <= (pend_cnt == 3'd1);
      pend        <= {8'd0, pend[3:1]};
      pend_cnt    <= pend_cnt - 3'd1;
    end else if (out_free) begin
      out_valid <= 1'b0;
    end
  end

endmodule

### rtl/svc_enc.sv
module svc_enc (
  input  logic [31:0]          value,
  output logic [2:0]           count,
  output svc_pkg::enc_bytes_t  enc_bytes
);

  logic neg;

  always_comb begin
    neg = value[31];
    if (!neg) begin
      if (value < svc_pkg::POS_LIM1) count = 3'd1;
      else if (value < svc_pkg::POS_LIM2) count = 3'd2;
      else if (value < svc_pkg::POS_LIM3) count = 3'd3;
      else if (value < svc_pkg::POS_LIM4) count = 3'd4;
      else count = 3'd5;
    end else begin
      if (value > svc_pkg::MASK_LEN1) count = 3'd1;
      else if (value > svc_pkg::MASK_LEN2) count = 3'd2;
      else if (value > svc_pkg::MASK_LEN3) count = 3'd3;
      else if (value > svc_pkg::MASK_LEN4) count = 3'd4;
      else count = 3'd5;
    end

    // continuation bit set on every byte but the final one
    enc_bytes[0] = {(count > 3'd1), neg, value[5:0]};
    enc_bytes[1] = {(count > 3'd2), value[12:6]};
    enc_bytes[2] = {(count > 3'd3), value[19:13]};
    enc_bytes[3] = {(count > 3'd4), value[26:20]};
    enc_bytes[4] = {4'd0, value[30:27]};
  end

endmodule

### rtl/svc_dec.sv
module svc_dec (
  input  logic                clk,
  input  logic                rst,
  input  logic                take,
  input  logic [7:0]          in_byte,
  input  logic                buffer_end,
  output svc_pkg::dec_res_t   dec
);

  logic [31:0] accumulator;
  logic [2:0]  byte_count;
  logic        negative_flag;

  logic [31:0] acc_next;
  logic        neg_next;
  logic [2:0]  count_next;
  logic [31:0] mask;
  logic        done;

  always_comb begin
    acc_next = accumulator;
    neg_next = negative_flag;
    case (byte_count)
      3'd0: begin
        acc_next = {26'd0, in_byte[5:0]};
        neg_next = in_byte[6];
      end
      3'd1: acc_next = accumulator | {19'd0, in_byte[6:0], 6'd0};
      3'd2: acc_next = accumulator | {12'd0, in_byte[6:0], 13'd0};
      3'd3: acc_next = accumulator | {5'd0, in_byte[6:0], 20'd0};
      default: acc_next = accumulator | {in_byte[4:0], 27'd0};
    endcase
    count_next = byte_count + 3'd1;
    done = !in_byte[7] || (count_next >= 3'd5);
    case (count_next)
      3'd1: mask = svc_pkg::MASK_LEN1;
      3'd2: mask = svc_pkg::MASK_LEN2;
      3'd3: mask = svc_pkg::MASK_LEN3;
      3'd4: mask = svc_pkg::MASK_LEN4;
      default: mask = svc_pkg::MASK_LEN5;
    endcase
    dec.valid = done || buffer_end;
    dec.kind  = done ? svc_pkg::RK_VALUE : svc_pkg::RK_TRUNC;
    dec.value = done ? (acc_next | (neg_next ? mask : 32'd0)) : 32'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      accumulator   <= '0;
      byte_count    <= '0;
      negative_flag <= 1'b0;
    end else if (take) begin
      if (done || buffer_end) begin
        accumulator   <= '0;
        byte_count    <= '0;
        negative_flag <= 1'b0;
      end else begin
        accumulator   <= acc_next;
        byte_count    <= count_next;
        negative_flag <= neg_next;
      end
    end
  end

endmodule
